@@ hw/rtl/csud_pkg.sv @@
// Shared types, codes and byte classification functions for the C string unescape decoder.
package csud_pkg;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX1   = 2'd2,
      MODE_HEX2   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_UNPRINTABLE    = 3'd1,
      ST_BAD_QUOTES     = 3'd2,
      ST_ESC_AT_END     = 3'd3,
      ST_INCOMPLETE_HEX = 3'd4,
      ST_UNKNOWN_ESC    = 3'd5,
      ST_BAD_HEX        = 3'd6
   } status_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;

   // Classified input byte, carried from front to back through the queue.
   typedef struct packed {
      logic [7:0] raw;
      logic       last;
      logic       printable;
      logic       is_quote;
      logic       is_bslash;
      logic       is_x;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       esc_ok;
      logic [7:0] esc_val;
   } class_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] val;
   } esc_type;

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type r;
      r.ok  = 1'b1;
      r.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.val = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic esc_type simple_escape(input logic [7:0] b);
      esc_type r;
      r.ok  = 1'b1;
      r.val = b;
      unique case (b)
         8'h27, 8'h22, 8'h3F, 8'h5C: r.val = b;
         8'h61: r.val = 8'h07;  // a
         8'h62: r.val = 8'h08;  // b
         8'h66: r.val = 8'h0C;  // f
         8'h6E: r.val = 8'h0A;  // n
         8'h72: r.val = 8'h0D;  // r
         8'h74: r.val = 8'h09;  // t
         8'h76: r.val = 8'h0B;  // v
         default: r.ok = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/csud_front.sv @@
// Front end: accepts raw bytes and classifies them for the decode queue.
module csud_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output csud_pkg::class_type   q_item
);
   import csud_pkg::*;

   hex_type hex;
   esc_type esc;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      hex = hex_value(req_tdata);
      esc = simple_escape(req_tdata);
      q_item.raw       = req_tdata;
      q_item.last      = req_tlast;
      q_item.printable = (req_tdata >= 8'h20) && (req_tdata <= 8'h7E);
      q_item.is_quote  = (req_tdata == CH_QUOTE);
      q_item.is_bslash = (req_tdata == CH_BSLASH);
      q_item.is_x      = (req_tdata == CH_X);
      q_item.hex_ok    = hex.ok;
      q_item.hex_val   = hex.val;
      q_item.esc_ok    = esc.ok;
      q_item.esc_val   = esc.val;
   end

endmodule

@@ hw/rtl/csud_queue.sv @@
// Short register queue between the classifying front end and the decoding back end.
module csud_queue #(
   parameter int DEPTH = csud_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csud_pkg::class_type   push_item,
   output logic                  full,
   input  logic                  pop,
   output csud_pkg::class_type   head_item,
   output logic                  empty
);
   import csud_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/csud_back.sv @@
// Back end: escape decoding state machine, error ranking and the result register.
module csud_back (
   input  logic                  clock,
   input  logic                  reset,
   input  csud_pkg::class_type   item,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import csud_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [3:0]  high_ff, high_in;
   logic        at_start_ff, at_start_in;
   logic        unpr_ff, unpr_in;
   logic        qbad_ff, qbad_in;
   status_type  perr_ff, perr_in;
   logic        badhex_ff, badhex_in;

   logic        out_vld_ff, out_vld_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   status_type  out_st_ff, out_st_in;
   logic        out_flag_ff, out_flag_in;
   logic        out_last_ff, out_last_in;

   logic        emit;
   logic [7:0]  emit_byte;

   assign q_pop      = !q_empty && (!out_vld_ff || rsp_tready);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_st_ff, out_byte_ff};
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      mode_in     = mode_ff;
      high_in     = high_ff;
      at_start_in = at_start_ff;
      unpr_in     = unpr_ff;
      qbad_in     = qbad_ff;
      perr_in     = perr_ff;
      badhex_in   = badhex_ff;
      emit        = 1'b0;
      emit_byte   = item.raw;

      out_vld_in  = out_vld_ff && !rsp_tready;
      out_byte_in = out_byte_ff;
      out_st_in   = out_st_ff;
      out_flag_in = out_flag_ff;
      out_last_in = out_last_ff;

      if (q_pop) begin
         unpr_in = unpr_ff || !item.printable;
         if (item.last) begin
            qbad_in = qbad_ff || !item.is_quote;
            if (!at_start_ff && perr_ff == ST_OK) begin
               unique case (mode_ff)
                  MODE_ESC:             perr_in = ST_ESC_AT_END;
                  MODE_HEX1, MODE_HEX2: perr_in = ST_INCOMPLETE_HEX;
                  default:              perr_in = ST_OK;
               endcase
            end
            out_vld_in  = 1'b1;
            out_byte_in = 8'd0;
            out_flag_in = 1'b0;
            out_last_in = 1'b1;
            out_st_in   = unpr_in ? ST_UNPRINTABLE :
                          qbad_in ? ST_BAD_QUOTES  : perr_in;
            // return to the start-of-string state
            mode_in     = MODE_NORMAL;
            high_in     = 4'd0;
            at_start_in = 1'b1;
            unpr_in     = 1'b0;
            qbad_in     = 1'b0;
            perr_in     = ST_OK;
            badhex_in   = 1'b0;
         end else if (at_start_ff) begin
            at_start_in = 1'b0;
            qbad_in     = qbad_ff || !item.is_quote;
         end else if (perr_ff == ST_OK) begin
            unique case (mode_ff)
               MODE_NORMAL: begin
                  if (item.is_bslash) begin
                     mode_in = MODE_ESC;
                  end else begin
                     emit = 1'b1;
                  end
               end
               MODE_ESC: begin
                  if (item.is_x) begin
                     mode_in = MODE_HEX1;
                  end else begin
                     mode_in = MODE_NORMAL;
                     if (item.esc_ok) begin
                        emit      = 1'b1;
                        emit_byte = item.esc_val;
                     end else begin
                        perr_in = ST_UNKNOWN_ESC;
                     end
                  end
               end
               MODE_HEX1: begin
                  badhex_in = !item.hex_ok;
                  high_in   = item.hex_ok ? item.hex_val : 4'd0;
                  mode_in   = MODE_HEX2;
               end
               MODE_HEX2: begin
                  mode_in = MODE_NORMAL;
                  if (badhex_ff || !item.hex_ok) begin
                     perr_in = ST_BAD_HEX;
                  end else begin
                     emit      = 1'b1;
                     emit_byte = {high_ff, item.hex_val};
                  end
                  badhex_in = 1'b0;
                  high_in   = 4'd0;
               end
               default: mode_in = MODE_NORMAL;
            endcase
         end
         if (emit) begin
            out_vld_in  = 1'b1;
            out_byte_in = emit_byte;
            out_flag_in = 1'b1;
            out_last_in = 1'b0;
            out_st_in   = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         high_ff     <= 4'd0;
         at_start_ff <= 1'b1;
         unpr_ff     <= 1'b0;
         qbad_ff     <= 1'b0;
         perr_ff     <= ST_OK;
         badhex_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         high_ff     <= high_in;
         at_start_ff <= at_start_in;
         unpr_ff     <= unpr_in;
         qbad_ff     <= qbad_in;
         perr_ff     <= perr_in;
         badhex_ff   <= badhex_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_st_ff   <= out_st_in;
      out_flag_ff <= out_flag_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ hw/rtl/c_string_unescape_decoder_unit.sv @@
// Top level of the C string unescape decoder: front end, queue and back end.
//
//   channel   direction  transaction carries
//   req_*     in         tdata[7:0] raw byte, tlast final byte of the string
//   rsp_*     out        tdata[7:0] decoded byte, tdata[10:8] status,
//                        tuser decoded byte present, tlast status result
//
// One byte per cycle sustained while rsp_tready stays high; a byte's result passes
// through the queue entry, then the result register behind the decode state machine.
// Reset clears the queue, the decode state and the result register.
// A stalled rsp side fills the queue; req_tready drops only when the queue is full.
module c_string_unescape_decoder_unit #(
   parameter int QUEUE_DEPTH = csud_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   output logic        rsp_tuser,   // out_valid
   output logic        rsp_tlast    // out_done
);
   import csud_pkg::*;

   class_type push_item;
   class_type head_item;
   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_empty;

   csud_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   csud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (head_item),
      .empty     (q_empty)
   );

   csud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (head_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ verif/c_string_unescape_decoder_unit_check.sv @@
// Checker for the C string unescape decoder: predicts every response from the accepted bytes.
module c_string_unescape_decoder_unit_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   input  logic        rsp_tuser,   // out_valid
   input  logic        rsp_tlast,   // out_done
   output int          fail_count,
   output int          pending_count,
   output int          decoded_count,
   output int          status_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import csud_pkg::*;

   typedef struct packed {
      logic [15:0] data;
      logic        has_byte;
      logic        done;
   } result_type;

   result_type pending_results[$];

   mode_type   mode;
   logic [3:0] nibble;
   logic       first_pending;
   logic       saw_unprintable;
   logic       quote_wrong;
   status_type first_error;
   logic       hex_bad;

   // {ok, value}; ok is low for a byte that is not a hex digit
   function automatic logic [4:0] digit_value(input logic [7:0] b);
      if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
      if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
      if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
      return 5'd0;
   endfunction

   // {ok, value} for the byte that follows a backslash
   function automatic logic [8:0] escape_code(input logic [7:0] b);
      case (b)
         "'", "\"", "?", "\\": return {1'b1, b};
         "a": return {1'b1, 8'h07};
         "b": return {1'b1, 8'h08};
         "f": return {1'b1, 8'h0C};
         "n": return {1'b1, 8'h0A};
         "r": return {1'b1, 8'h0D};
         "t": return {1'b1, 8'h09};
         "v": return {1'b1, 8'h0B};
         default: return 9'd0;
      endcase
   endfunction

   task automatic clear_decoder();
      mode            = MODE_NORMAL;
      nibble          = 4'd0;
      first_pending   = 1'b1;
      saw_unprintable = 1'b0;
      quote_wrong     = 1'b0;
      first_error     = ST_OK;
      hex_bad         = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic fin);
      logic [4:0] hv;
      logic [8:0] ev;
      logic       emit;
      logic [7:0] ch;
      status_type st;
      emit = 1'b0;
      ch   = 8'd0;
      if (b < 8'h20 || b > 8'h7E) saw_unprintable = 1'b1;
      if (fin) begin
         if (b != CH_QUOTE) quote_wrong = 1'b1;
         // a string cut off inside an escape reports that before a bad digit
         if (!first_pending && first_error == ST_OK) begin
            if (mode == MODE_ESC) first_error = ST_ESC_AT_END;
            else if (mode == MODE_HEX1 || mode == MODE_HEX2) first_error = ST_INCOMPLETE_HEX;
         end
         if (saw_unprintable) st = ST_UNPRINTABLE;
         else if (quote_wrong) st = ST_BAD_QUOTES;
         else st = first_error;
         pending_results.push_back('{data: {5'd0, st, 8'd0}, has_byte: 1'b0, done: 1'b1});
         clear_decoder();
      end else if (first_pending) begin
         first_pending = 1'b0;
         if (b != CH_QUOTE) quote_wrong = 1'b1;
      end else if (first_error == ST_OK) begin
         case (mode)
            MODE_NORMAL: begin
               if (b == CH_BSLASH) mode = MODE_ESC;
               else begin
                  emit = 1'b1;
                  ch   = b;
               end
            end
            MODE_ESC: begin
               if (b == CH_X) mode = MODE_HEX1;
               else begin
                  ev   = escape_code(b);
                  mode = MODE_NORMAL;
                  if (ev[8]) begin
                     emit = 1'b1;
                     ch   = ev[7:0];
                  end else first_error = ST_UNKNOWN_ESC;
               end
            end
            MODE_HEX1: begin
               hv      = digit_value(b);
               hex_bad = !hv[4];
               nibble  = hv[4] ? hv[3:0] : 4'd0;
               mode    = MODE_HEX2;
            end
            default: begin
               hv   = digit_value(b);
               mode = MODE_NORMAL;
               if (hex_bad || !hv[4]) first_error = ST_BAD_HEX;
               else begin
                  emit = 1'b1;
                  ch   = {nibble, hv[3:0]};
               end
               hex_bad = 1'b0;
               nibble  = 4'd0;
            end
         endcase
         if (emit) pending_results.push_back('{data: {8'd0, ch}, has_byte: 1'b1, done: 1'b0});
      end
   endtask

   task automatic compare_result();
      result_type want;
      if (pending_results.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected transaction, expected none, got tdata=%h tuser=%b tlast=%b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = pending_results.pop_front();
         if (rsp_tdata !== want.data) begin
            fail_count++;
            $display("%0t: tdata mismatch, expected %h, got %h", $time, want.data, rsp_tdata);
         end
         if (rsp_tuser !== want.has_byte) begin
            fail_count++;
            $display("%0t: tuser mismatch, expected %b, got %b", $time, want.has_byte, rsp_tuser);
         end
         if (rsp_tlast !== want.done) begin
            fail_count++;
            $display("%0t: tlast mismatch, expected %b, got %b", $time, want.done, rsp_tlast);
         end
         if (want.done) status_count++;
         else decoded_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      decoded_count = 0;
      status_count  = 0;
      clear_decoder();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         pending_results.delete();
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) compare_result();
      end
      pending_count = pending_results.size();
   end

endmodule

@@ verif/c_string_unescape_decoder_unit_test.sv @@
// Stimulus and verdict for the C string unescape decoder: quoted strings, escapes and bad input.
module c_string_unescape_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import csud_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;   // in_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [10:8] status, rest zero
   logic        rsp_tuser;   // out_valid
   logic        rsp_tlast;   // out_done

   int fail_count;
   int pending_count;
   int decoded_count;
   int status_count;

   logic       steady;
   int         bytes_sent;
   int         strings_sent;
   logic [7:0] text_q[$];

   const logic [7:0] escape_chars[11] = '{8'h27, 8'h22, 8'h3F, 8'h5C, 8'h61, 8'h62,
                                          8'h66, 8'h6E, 8'h72, 8'h74, 8'h76};

   c_string_unescape_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   c_string_unescape_decoder_unit_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .decoded_count (decoded_count),
      .status_count  (status_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("c_string_unescape_decoder_unit_test NOT OK");
      $finish;
   end

   // stall the response side at random, except during the steady stretch
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = steady || ($urandom_range(0, 99) >= 19);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_queue();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      strings_sent++;
   endtask

   task automatic send_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_queue();
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (upper ? 8'h37 : 8'h57) + 8'(v);
   endfunction

   task automatic push_hex_escape();
      text_q.push_back(CH_BSLASH);
      text_q.push_back(CH_X);
      text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
      text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
   endtask

   // mostly well-formed strings with random content; a few broken ones
   task automatic build_random_string();
      int         n;
      int         pick;
      logic [7:0] b;
      text_q.delete();
      text_q.push_back($urandom_range(0, 99) < 95 ? CH_QUOTE : 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 7);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            b = 8'($urandom_range(8'h20, 8'h7E));
            text_q.push_back(b);
            // keep a plain backslash from opening an escape
            if (b == CH_BSLASH) text_q.push_back(b);
         end else if (pick < 65) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(escape_chars[$urandom_range(0, 10)]);
         end else if (pick < 85) begin
            push_hex_escape();
         end else if (pick < 90) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (pick < 94) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_X);
            text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         text_q.push_back(CH_BSLASH);
      end else if (pick < 8) begin
         // cut a hex escape short, sometimes after one random byte
         text_q.push_back(CH_BSLASH);
         text_q.push_back(CH_X);
         if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      text_q.push_back($urandom_range(0, 99) < 92 ? CH_QUOTE : 8'($urandom_range(0, 255)));
      send_queue();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'd0;
      req_tlast    = 1'b0;
      steady       = 1'b0;
      bytes_sent   = 0;
      strings_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text("\"");
      send_text("x");
      text_q = '{8'hFF, 8'h61, 8'h00, CH_QUOTE};
      send_queue();
      send_text("\"\\xg\"");
      send_text("\"\\\"");
      send_text("\"\\qz\"");
      send_text("\"\\xaF\"");

      while (bytes_sent < 540) begin
         steady = (bytes_sent >= 250 && bytes_sent < 370);
         build_random_string();
      end
      steady     = 1'b0;
      req_tvalid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d strings in %0d bytes: clean, escaped, truncated and malformed",
               strings_sent, bytes_sent);
      $display("Compared %0d decoded bytes and %0d status transactions",
               decoded_count, status_count);
      if (fail_count == 0) begin
         $display("c_string_unescape_decoder_unit_test OK");
      end else begin
         $display("c_string_unescape_decoder_unit_test NOT OK");
      end
      $finish;
   end

endmodule
